FILE: sv/assert_macros.svh
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RIF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define RIF_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/rif_pkg.sv
// Shared types and constants of the recent id filter.
package rif_pkg;

  localparam int IdW         = 32;
  localparam int TimeW       = 32;
  localparam int DefaultSlots = 9;

  localparam logic [TimeW-1:0] ExpiryReset = TimeW'(18);

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] last_seen;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic is_new;
  } scan_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } scan_state_t;

endpackage

FILE: sv/recent_id_filter_with_expiry.sv
// Top level of the recent id filter: expiry register, table, walker, output register.
//
// Each id is looked up in a table of TABLE_SLOTS slots held in a memory with a
// registered read. The walker issues one slot read per cycle and checks each slot
// the cycle after, ending at the last slot or earlier when the id is found, and
// takes no new id until its result has moved into an output register. The next
// id is accepted while that result still waits to be taken. The table reads as
// empty after reset, with no clearing pass. The expiry window resets to 18
// seconds; the user must write it through cfg_wr_en / cfg_wr_data only while
// the block is idle, which the block itself does not enforce.

module recent_id_filter_with_expiry #(
  parameter int TABLE_SLOTS = rif_pkg::DefaultSlots
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rif_pkg::IdW-1:0]    in_sender_id,
  input  logic [rif_pkg::TimeW-1:0]  in_now_seconds,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_is_new,
  input  logic                       cfg_wr_en,
  input  logic [rif_pkg::TimeW-1:0]  cfg_wr_data
);
  import rif_pkg::*;

  localparam int SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  logic [TimeW-1:0] expiry_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_is_new_r, out_is_new_nxt;

  logic             rd_en;
  logic [SlotW-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [SlotW-1:0] wr_addr;
  entry_t           wr_data;
  scan_res_t        res;
  logic             res_taken;

  rif_mem #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SlotW       (SlotW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  rif_scan #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SlotW       (SlotW)
  ) u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sender_id   (in_sender_id),
    .in_now_seconds (in_now_seconds),
    .expiry_window  (expiry_r),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .res            (res),
    .res_taken      (res_taken)
  );

  // Load a new beat whenever the output register is empty or being drained.
  assign res_taken = res.valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_is_new_nxt = out_is_new_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (res_taken) begin
      out_valid_nxt  = 1'b1;
      out_is_new_nxt = res.is_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r    <= ExpiryReset;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) expiry_r <= cfg_wr_data;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_is_new_r <= out_is_new_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_is_new = out_is_new_r;

endmodule

FILE: sv/rif_mem.sv
// Slot table memory: one write port, one registered read port, per-entry valid bits.
`include "assert_macros.svh"

module rif_mem #(
  parameter int TABLE_SLOTS = rif_pkg::DefaultSlots,
  parameter int SlotW       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [SlotW-1:0]     rd_addr,
  output rif_pkg::entry_t      rd_data,
  input  logic                 wr_en,
  input  logic [SlotW-1:0]     wr_addr,
  input  rif_pkg::entry_t      wr_data
);
  import rif_pkg::*;

  entry_t                 mem_r [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] valid_r;
  entry_t                 rd_q_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  // Valid bits make never-written entries read as empty with time zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

  `RIF_NEVER(a_rd_range, rd_en && (int'(rd_addr) >= TABLE_SLOTS), "read beyond table")
  `RIF_NEVER(a_wr_range, wr_en && (int'(wr_addr) >= TABLE_SLOTS), "write beyond table")

endmodule

FILE: sv/rif_scan.sv
// Slot walker: streams reads through the table, checks each slot, writes back.
`include "assert_macros.svh"

module rif_scan #(
  parameter int TABLE_SLOTS = rif_pkg::DefaultSlots,
  parameter int SlotW       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rif_pkg::IdW-1:0]    in_sender_id,
  input  logic [rif_pkg::TimeW-1:0]  in_now_seconds,
  input  logic [rif_pkg::TimeW-1:0]  expiry_window,
  output logic                       rd_en,
  output logic [SlotW-1:0]           rd_addr,
  input  rif_pkg::entry_t            rd_data,
  output logic                       wr_en,
  output logic [SlotW-1:0]           wr_addr,
  output rif_pkg::entry_t            wr_data,
  output rif_pkg::scan_res_t         res,
  input  logic                       res_taken
);
  import rif_pkg::*;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(TABLE_SLOTS - 1);

  scan_state_t      state_r, state_nxt;
  logic [IdW-1:0]   id_r, id_nxt;
  logic [TimeW-1:0] now_r, now_nxt;
  logic [SlotW-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_on_r, rd_on_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [SlotW-1:0] chk_idx_r, chk_idx_nxt;
  logic [SlotW-1:0] free_idx_r, free_idx_nxt;
  logic             is_new_r, is_new_nxt;

  logic             accept;
  logic             slot_empty;
  logic             slot_match;
  logic             slot_expired;
  logic [TimeW-1:0] age;
  logic [SlotW-1:0] free_sel;
  logic             finish;

  assign accept = in_valid && in_ready;

  // Check stage: rd_data belongs to slot chk_idx_r.
  always_comb begin
    age          = now_r - rd_data.last_seen;
    slot_empty   = (rd_data.id == '0);
    slot_match   = !slot_empty && (rd_data.id == id_r);
    slot_expired = (age > expiry_window);
    free_sel     = (slot_empty || (!slot_match && slot_expired)) ? chk_idx_r : free_idx_r;
    finish       = chk_vld_r && (slot_match || (chk_idx_r == LastSlot));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (finish) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_taken) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    res.valid    = (state_r == ST_RESULT);
    res.is_new   = is_new_r;
    id_nxt       = id_r;
    now_nxt      = now_r;
    rd_idx_nxt   = rd_idx_r;
    rd_on_nxt    = rd_on_r;
    chk_vld_nxt  = 1'b0;
    chk_idx_nxt  = rd_idx_r;
    free_idx_nxt = free_idx_r;
    is_new_nxt   = is_new_r;
    rd_en        = 1'b0;
    rd_addr      = rd_idx_r;
    wr_en        = 1'b0;
    wr_addr      = chk_idx_r;
    wr_data      = '{id: id_r, last_seen: now_r};

    if (accept) begin
      id_nxt       = in_sender_id;
      now_nxt      = in_now_seconds;
      rd_idx_nxt   = '0;
      rd_on_nxt    = 1'b1;
      free_idx_nxt = '0;
    end

    if (state_r == ST_SCAN) begin
      // Issue one read per cycle until the last slot is requested or a match ends the walk.
      rd_en       = rd_on_r;
      chk_vld_nxt = rd_on_r;
      if (rd_on_r) begin
        if (rd_idx_r == LastSlot) rd_on_nxt = 1'b0;
        else rd_idx_nxt = rd_idx_r + SlotW'(1);
      end

      if (chk_vld_r) begin
        free_idx_nxt = free_sel;
        priority if (slot_match) begin
          // Refresh the time stamp of the matching slot.
          wr_en      = 1'b1;
          wr_data    = '{id: rd_data.id, last_seen: now_r};
          is_new_nxt = slot_expired;
        end else if (chk_idx_r == LastSlot) begin
          // No match anywhere: insert into the last free slot seen, or slot zero if none.
          wr_en      = 1'b1;
          wr_addr    = free_sel;
          is_new_nxt = 1'b1;
        end else if (!slot_empty && slot_expired) begin
          // Drop the stale id, keep its time stamp.
          wr_en   = 1'b1;
          wr_data = '{id: '0, last_seen: rd_data.last_seen};
        end
      end

      if (finish) begin
        rd_on_nxt   = 1'b0;
        chk_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_on_r   <= 1'b0;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_on_r   <= rd_on_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    now_r      <= now_nxt;
    rd_idx_r   <= rd_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    free_idx_r <= free_idx_nxt;
    is_new_r   <= is_new_nxt;
  end

  `RIF_NEVER(a_rw_same_slot, rd_en && wr_en && (rd_addr == wr_addr), "read and write hit one slot")
  `RIF_ASSERT(a_start_scan, accept |=> (state_r == ST_SCAN) && rd_on_r && (rd_idx_r == '0) && !chk_vld_r, "scan did not start at slot zero")
  `RIF_ASSERT(a_one_write_finish, finish |-> wr_en, "walk ended without a write")
  `RIF_NEVER(a_check_outside_scan, chk_vld_r && (state_r != ST_SCAN), "slot checked outside a walk")

endmodule
